// ===== rtl/ufcef_pkg.sv =====
// Shared widths and constants for the union-find cycle edge filter.
package ufcef_pkg;

  localparam int unsigned VIDX_W   = 10;
  localparam int unsigned VCNT_W   = 11;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned EPOCH_W  = 6;

  localparam logic [RANK_W-1:0]  RANK_MAX     = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX    = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST  = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_STALE  = '0;
  localparam logic [VCNT_W-1:0]  VCOUNT_RESET = VCNT_W'(1024);

  localparam logic signed [SUM_W-1:0] SUM_POS_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_NEG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

// ===== rtl/ufcef_forest_mem.sv =====
// Single-port-write, single-port-read forest store with registered read data.
module ufcef_forest_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 20
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ufcef_sat_acc.sv =====
// Saturating accumulator for the weights of removed edges.
module ufcef_sat_acc (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     clr_i,
  input  logic                                     add_i,
  input  logic signed [ufcef_pkg::WEIGHT_W-1:0]    weight_i,
  output logic signed [ufcef_pkg::SUM_W-1:0]       acc_o
);

  logic signed [ufcef_pkg::SUM_W-1:0] acc_q;
  logic signed [ufcef_pkg::SUM_W:0]   sum;
  logic signed [ufcef_pkg::SUM_W-1:0] sat;

  always_comb begin
    sum = {acc_q[ufcef_pkg::SUM_W-1], acc_q}
        + (ufcef_pkg::SUM_W+1)'(weight_i);
    // top two bits differ: the sum left the 32-bit range
    if (sum[ufcef_pkg::SUM_W] == sum[ufcef_pkg::SUM_W-1]) begin
      sat = sum[ufcef_pkg::SUM_W-1:0];
    end else if (sum[ufcef_pkg::SUM_W]) begin
      sat = ufcef_pkg::SUM_NEG_LIMIT;
    end else begin
      sat = ufcef_pkg::SUM_POS_LIMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clr_i) begin
      acc_q <= '0;
    end else if (add_i) begin
      acc_q <= sat;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/ufcef_core.sv =====
// Sequencer: clearing sweep, two root walks, rank merge and result register.
module ufcef_core #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [ufcef_pkg::VCNT_W-1:0]          vertex_count_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  new_graph_i,
  input  logic [ufcef_pkg::VIDX_W-1:0]          end_a_i,
  input  logic [ufcef_pkg::VIDX_W-1:0]          end_b_i,
  input  logic signed [ufcef_pkg::WEIGHT_W-1:0] edge_weight_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  edge_removed_o,
  output logic signed [ufcef_pkg::SUM_W-1:0]    removed_weight_sum_o,
  output logic                                  index_error_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned SW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned RW = ufcef_pkg::RANK_W;
  localparam int unsigned EW = ufcef_pkg::EPOCH_W;
  localparam int unsigned DW = EW + AW + RW;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_FIND_A = 3'd3;
  localparam logic [2:0] S_FIND_B = 3'd4;
  localparam logic [2:0] S_MERGE  = 3'd5;
  localparam logic [2:0] S_RANKUP = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]                          state_q, state_d;
  logic                                pend_q;
  logic [EW-1:0]                       epoch_q;
  logic [AW-1:0]                       clr_q;
  logic [ufcef_pkg::VIDX_W-1:0]        a_q, b_q;
  logic signed [ufcef_pkg::WEIGHT_W-1:0] w_q;
  logic                                err_q;
  logic                                removed_q;
  logic [AW-1:0]                       cur_q;
  logic [SW-1:0]                       steps_q;
  logic [AW-1:0]                       ra_q, rb_q;
  logic [RW-1:0]                       rka_q, rkb_q;
  logic                                out_valid_q;
  logic                                out_removed_q;
  logic                                out_err_q;
  logic signed [ufcef_pkg::SUM_W-1:0]  out_sum_q;

  logic                                accept;
  logic                                in_err;
  logic                                mem_we;
  logic [AW-1:0]                       mem_waddr;
  logic [DW-1:0]                       mem_wdata;
  logic [AW-1:0]                       mem_raddr;
  logic [DW-1:0]                       mem_rdata;
  logic                                ent_hit;
  logic [AW-1:0]                       ent_par;
  logic [RW-1:0]                       ent_rank;
  logic                                at_root;
  logic                                out_load;
  logic                                acc_clr;
  logic                                acc_add;
  logic signed [ufcef_pkg::SUM_W-1:0]  acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign in_err = ({1'b0, end_a_i} >= vertex_count_i) || ({1'b0, end_b_i} >= vertex_count_i)
               || (32'(end_a_i) >= MAX_VERTICES) || (32'(end_b_i) >= MAX_VERTICES);

  // stale epoch tag: the entry reads as a fresh self-rooted vertex of rank zero
  assign ent_hit  = (mem_rdata[DW-1 -: EW] == epoch_q);
  assign ent_par  = ent_hit ? mem_rdata[RW +: AW] : cur_q;
  assign ent_rank = ent_hit ? mem_rdata[RW-1:0] : '0;
  assign at_root  = (ent_par == cur_q) || (steps_q == SW'(MAX_VERTICES));

  assign acc_clr = accept && new_graph_i;
  assign acc_add = (state_q == S_MERGE) && (ra_q == rb_q);

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = ra_q;
    mem_wdata = {epoch_q, ra_q, rka_q};
    mem_raddr = cur_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {ufcef_pkg::EPOCH_STALE, {(AW+RW){1'b0}}};
        if (clr_q == AW'(MAX_VERTICES - 1)) begin
          state_d = pend_q ? S_PREP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = (new_graph_i && (epoch_q == ufcef_pkg::EPOCH_MAX)) ? S_CLEAR : S_PREP;
        end
      end
      S_PREP: begin
        mem_raddr = AW'(a_q);
        state_d   = err_q ? S_DONE : S_FIND_A;
      end
      S_FIND_A: begin
        if (at_root) begin
          mem_raddr = AW'(b_q);
          state_d   = S_FIND_B;
        end else begin
          mem_raddr = ent_par;
        end
      end
      S_FIND_B: begin
        if (at_root) begin
          state_d = S_MERGE;
        end else begin
          mem_raddr = ent_par;
        end
      end
      S_MERGE: begin
        state_d = S_DONE;
        if (ra_q != rb_q) begin
          mem_we = 1'b1;
          if (rka_q < rkb_q) begin
            mem_waddr = ra_q;
            mem_wdata = {epoch_q, rb_q, rka_q};
          end else begin
            mem_waddr = rb_q;
            mem_wdata = {epoch_q, ra_q, rkb_q};
            if ((rka_q == rkb_q) && (rka_q != ufcef_pkg::RANK_MAX)) begin
              state_d = S_RANKUP;
            end
          end
        end
      end
      S_RANKUP: begin
        mem_we    = 1'b1;
        mem_waddr = ra_q;
        mem_wdata = {epoch_q, ra_q, rka_q + 1'b1};
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pend_q      <= 1'b0;
      epoch_q     <= ufcef_pkg::EPOCH_FIRST;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        pend_q <= 1'b1;
        if (new_graph_i) begin
          if (epoch_q == ufcef_pkg::EPOCH_MAX) begin
            epoch_q <= ufcef_pkg::EPOCH_FIRST;
            clr_q   <= '0;
          end else begin
            epoch_q <= epoch_q + 1'b1;
          end
        end
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q       <= end_a_i;
      b_q       <= end_b_i;
      w_q       <= edge_weight_i;
      err_q     <= in_err;
      removed_q <= 1'b0;
    end
    unique case (state_q)
      S_PREP: begin
        cur_q   <= AW'(a_q);
        steps_q <= '0;
      end
      S_FIND_A: begin
        if (at_root) begin
          ra_q    <= cur_q;
          rka_q   <= ent_rank;
          cur_q   <= AW'(b_q);
          steps_q <= '0;
        end else begin
          cur_q   <= ent_par;
          steps_q <= steps_q + 1'b1;
        end
      end
      S_FIND_B: begin
        if (at_root) begin
          rb_q  <= cur_q;
          rkb_q <= ent_rank;
        end else begin
          cur_q   <= ent_par;
          steps_q <= steps_q + 1'b1;
        end
      end
      S_MERGE: begin
        removed_q <= (ra_q == rb_q);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_removed_q <= removed_q;
      out_err_q     <= err_q;
      out_sum_q     <= acc;
    end
  end

  ufcef_forest_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ufcef_sat_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (acc_clr),
    .add_i    (acc_add),
    .weight_i (w_q),
    .acc_o    (acc)
  );

  assign out_valid_o          = out_valid_q;
  assign edge_removed_o       = out_removed_q;
  assign removed_weight_sum_o = out_sum_q;
  assign index_error_o        = out_err_q;

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIND_A) || (state_q == S_FIND_B)) |-> (steps_q <= SW'(MAX_VERTICES)))
    else $error("root walk ran past the step bound");

  a_rankup_only_on_tie: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RANKUP) |-> ((rka_q == rkb_q) && (ra_q != rb_q)
                               && (rka_q != ufcef_pkg::RANK_MAX)))
    else $error("rank raised without an equal-rank merge");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_removed_q && out_err_q))
    else $error("result flags both removal and index error");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((state_q == S_PREP) || (state_q == S_CLEAR)))
    else $error("accepted word did not start processing");

endmodule

// ===== rtl/union_find_cycle_edge_filter.sv =====
// Top level: configuration register file and the union-find edge filter core.
// Each word walks the parent links from end_a, then from end_b, then merges, with an
// extra rank update on an equal-rank merge below RANK_MAX; an index error skips both.
// One word at a time: no new word is taken until the result enters the output register.
// Reset clears the sum and output valid; a clearing pass over every forest entry
// follows reset and every 63rd new-graph mark, with in_stall_o high throughout.
module union_find_cycle_edge_filter #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  // edge input
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  new_graph_i,
  input  logic [ufcef_pkg::VIDX_W-1:0]          end_a_i,
  input  logic [ufcef_pkg::VIDX_W-1:0]          end_b_i,
  input  logic signed [ufcef_pkg::WEIGHT_W-1:0] edge_weight_i,
  // result output
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  edge_removed_o,
  output logic signed [ufcef_pkg::SUM_W-1:0]    removed_weight_sum_o,
  output logic                                  index_error_o
);

  logic [ufcef_pkg::VCNT_W-1:0] vcount_q;
  logic                         cfg_wr;

  // Vertex count register lives at byte address 0; the next word is unmapped.
  // A write does not touch the forest: existing links survive a count change.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= ufcef_pkg::VCOUNT_RESET;
    end else if (cfg_wr && !paddr[2]) begin
      vcount_q <= pwdata[ufcef_pkg::VCNT_W-1:0];
    end
  end

  assign prdata = paddr[2] ? '0 : {{(32-ufcef_pkg::VCNT_W){1'b0}}, vcount_q};

  // The core walks both roots one parent link per cycle through a shared
  // compare on the registered forest read, then merges by rank. Forest
  // entries carry an epoch tag, so most new-graph marks need no clearing pass.
  ufcef_core #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .vertex_count_i       (vcount_q),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .new_graph_i          (new_graph_i),
    .end_a_i              (end_a_i),
    .end_b_i              (end_b_i),
    .edge_weight_i        (edge_weight_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .edge_removed_o       (edge_removed_o),
    .removed_weight_sum_o (removed_weight_sum_o),
    .index_error_o        (index_error_o)
  );

endmodule

// ===== dv/union_find_cycle_edge_filter_tb.sv =====
// Self-checking testbench for the union-find cycle edge filter.
module union_find_cycle_edge_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FOREST_SIZE  = 1024;
  localparam logic [2:0]  VCOUNT_ADDR  = 3'd0;   // vertex_count register
  localparam int unsigned DRAIN_CYCLES = 64;     // comfortably above the worst find latency
  localparam int unsigned HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_WORDS  = 75;
  localparam int unsigned POS_RUN      = 8;      // back-to-back +32767 self loops
  localparam int unsigned NEG_RUN      = 8;      // back-to-back -32768 self loops

  typedef struct packed {
    logic                               removed;
    logic signed [ufcef_pkg::SUM_W-1:0] sum;
    logic                               bad_index;
  } edge_verdict_t;

  // Mirrors the forest, the removed-weight sum and the vertex count; holds the
  // verdicts still owed by the block, oldest first.
  class cycle_edge_tracker;
    logic [ufcef_pkg::VIDX_W-1:0]       parent_of [FOREST_SIZE];
    logic [ufcef_pkg::RANK_W-1:0]       rank_of [FOREST_SIZE];
    logic signed [ufcef_pkg::SUM_W-1:0] removed_sum;
    logic [ufcef_pkg::VCNT_W-1:0]       vertex_count;
    edge_verdict_t                      verdicts_due[$];
    int unsigned                        mismatches;

    function new();
      clear_forest();
      vertex_count = ufcef_pkg::VCOUNT_RESET;
      mismatches   = 0;
    endfunction

    function void clear_forest();
      for (int v = 0; v < FOREST_SIZE; v++) begin
        parent_of[v] = ufcef_pkg::VIDX_W'(v);
        rank_of[v]   = '0;
      end
      removed_sum = '0;
    endfunction

    // Walk parent links without compression; give up after a full sweep.
    function logic [ufcef_pkg::VIDX_W-1:0] root_of(logic [ufcef_pkg::VIDX_W-1:0] v);
      logic [ufcef_pkg::VIDX_W-1:0] node;
      node = v;
      for (int s = 0; s < FOREST_SIZE; s++) begin
        if (parent_of[node] == node) break;
        node = parent_of[node];
      end
      return node;
    endfunction

    function void note_edge(logic new_graph, logic [ufcef_pkg::VIDX_W-1:0] a,
                            logic [ufcef_pkg::VIDX_W-1:0] b,
                            logic signed [ufcef_pkg::WEIGHT_W-1:0] w);
      int unsigned                  lim;
      logic [ufcef_pkg::VIDX_W-1:0] ra, rb;
      longint                       total;
      edge_verdict_t                verdict;
      lim = (vertex_count > FOREST_SIZE) ? FOREST_SIZE : int'(vertex_count);
      if (new_graph) clear_forest();
      verdict.removed   = 1'b0;
      verdict.bad_index = 1'b0;
      if (a >= lim || b >= lim) begin
        verdict.bad_index = 1'b1;
      end else begin
        ra = root_of(a);
        rb = root_of(b);
        if (ra != rb) begin
          if (rank_of[ra] < rank_of[rb]) begin
            parent_of[ra] = rb;
          end else if (rank_of[ra] > rank_of[rb]) begin
            parent_of[rb] = ra;
          end else begin
            // tie: second root hangs under the first, which gains rank below RANK_MAX
            parent_of[rb] = ra;
            if (rank_of[ra] != ufcef_pkg::RANK_MAX) rank_of[ra] = rank_of[ra] + 1'b1;
          end
        end else begin
          total = longint'(removed_sum) + longint'(w);
          if (total > longint'(ufcef_pkg::SUM_POS_LIMIT))
            total = longint'(ufcef_pkg::SUM_POS_LIMIT);
          if (total < longint'(ufcef_pkg::SUM_NEG_LIMIT))
            total = longint'(ufcef_pkg::SUM_NEG_LIMIT);
          removed_sum     = ufcef_pkg::SUM_W'(total);
          verdict.removed = 1'b1;
        end
      end
      verdict.sum = removed_sum;
      verdicts_due.insert(verdicts_due.size(), verdict);
    endfunction

    function void check_verdict(logic removed, logic signed [ufcef_pkg::SUM_W-1:0] sum,
                                logic bad_index);
      edge_verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected word: edge_removed=%0b removed_weight_sum=%0d index_error=%0b",
                 $time, removed, sum, bad_index);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      if (removed !== want.removed) begin
        $display("%0t: edge_removed expected %0b actual %0b", $time, want.removed, removed);
        mismatches++;
      end
      if (sum !== want.sum) begin
        $display("%0t: removed_weight_sum expected %0d actual %0d", $time, want.sum, sum);
        mismatches++;
      end
      if (bad_index !== want.bad_index) begin
        $display("%0t: index_error expected %0b actual %0b", $time, want.bad_index, bad_index);
        mismatches++;
      end
    endfunction

    function void report_leftovers();
      if (verdicts_due.size() != 0) begin
        $display("%0t: %0d words never arrived, oldest expected sum %0d, actual none",
                 $time, verdicts_due.size(), verdicts_due[0].sum);
        mismatches += verdicts_due.size();
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  psel;
  logic                                  penable;
  logic                                  pwrite;
  logic [2:0]                            paddr;
  logic [31:0]                           pwdata;
  logic [31:0]                           prdata;
  logic                                  pready;
  logic                                  in_valid_i;
  logic                                  in_stall_o;
  logic                                  new_graph_i;
  logic [ufcef_pkg::VIDX_W-1:0]          end_a_i;
  logic [ufcef_pkg::VIDX_W-1:0]          end_b_i;
  logic signed [ufcef_pkg::WEIGHT_W-1:0] edge_weight_i;
  logic                                  out_valid_o;
  logic                                  out_stall_i;
  logic                                  edge_removed_o;
  logic signed [ufcef_pkg::SUM_W-1:0]    removed_weight_sum_o;
  logic                                  index_error_o;

  cycle_edge_tracker tracker = new();

  // Idling controls shared between the sender and the receiver.
  bit fast_mode;    // drop all idling, used for the back-to-back runs
  bit hold_req;     // ask the receiver for one long hold-off
  bit offering;     // in_valid_i is currently high
  int burst_left;

  union_find_cycle_edge_filter dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .new_graph_i          (new_graph_i),
    .end_a_i              (end_a_i),
    .end_b_i              (end_b_i),
    .edge_weight_i        (edge_weight_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .edge_removed_o       (edge_removed_o),
    .removed_weight_sum_o (removed_weight_sum_o),
    .index_error_o        (index_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("union_find_cycle_edge_filter: mismatch");
    $finish;
  end

  // Check every word taken from the output against the oldest verdict owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_verdict(edge_removed_o, removed_weight_sum_o, index_error_o);
  end

  // Receiver: alternate free and stalled runs of random length, with the odd
  // long free stretch; honour one long hold-off on request.
  initial begin : receiver
    int hold_left;
    int run;
    bit level;
    hold_left   = 0;
    run         = 0;
    level       = 1'b1;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        if (run <= 0) begin
          level = !level;
          run   = level ? $urandom_range(1, 6) : $urandom_range(1, 14);
          if (!level && $urandom_range(0, 4) == 0) run = $urandom_range(30, 90);
        end
        out_stall_i <= level && !fast_mode;
        run--;
      end
    end
  end

  // Offer one edge word from a falling edge, hold it until taken, then, outside fast mode,
  // leave a random gap once the current burst is used up. Returns on a falling edge.
  task automatic send_edge(logic ng, logic [ufcef_pkg::VIDX_W-1:0] a,
                           logic [ufcef_pkg::VIDX_W-1:0] b,
                           logic signed [ufcef_pkg::WEIGHT_W-1:0] w);
    int gap;
    in_valid_i    <= 1'b1;
    offering       = 1'b1;
    new_graph_i   <= ng;
    end_a_i       <= a;
    end_b_i       <= b;
    edge_weight_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_edge(ng, a, b, w);
    @(negedge clk_i);
    if (!fast_mode) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          offering    = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
  endtask

  // Edge of a generated graph: weights mostly fall, now and then jump at random;
  // the odd stray new-graph mark lands mid-graph.
  task automatic send_graph_edge(logic mark, logic [ufcef_pkg::VIDX_W-1:0] a,
                                 logic [ufcef_pkg::VIDX_W-1:0] b, inout int w_cur);
    if ($urandom_range(0, 9) == 0) begin
      w_cur = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      w_cur = w_cur - int'($urandom_range(0, 1500));
      if (w_cur < -32768) w_cur = -32768;
    end
    send_edge(mark || ($urandom_range(0, 32) == 0), a, b, ufcef_pkg::WEIGHT_W'(w_cur));
  endtask

  // Endpoint: sometimes out of range, else from a small hot window (to close
  // cycles) or anywhere in range.
  function automatic logic [ufcef_pkg::VIDX_W-1:0] pick_end(int unsigned lim,
                                                            int unsigned hot);
    if (lim == 0 || (lim < FOREST_SIZE && $urandom_range(0, 11) == 0))
      return ufcef_pkg::VIDX_W'($urandom_range(lim, FOREST_SIZE - 1));
    if ($urandom_range(0, 1) == 1)
      return ufcef_pkg::VIDX_W'((hot + $urandom_range(0, 7)) % lim);
    return ufcef_pkg::VIDX_W'($urandom_range(0, lim - 1));
  endfunction

  // Write the vertex count through the setup and access phases.
  task automatic write_vertex_count(logic [ufcef_pkg::VCNT_W-1:0] count);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VCOUNT_ADDR;
    pwdata  <= {21'($urandom), count};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.vertex_count = count;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, wait for every verdict, let the pipeline drain and any
  // clearing pass finish.
  task automatic settle();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering    = 1'b0;
    end
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
  endtask

  // One vertex-count setting: a mix of doubling builds (deep, balanced trees)
  // and random edges around a hot window.
  task automatic run_phase(int unsigned lim, int unsigned budget);
    int unsigned sent;
    int unsigned span;
    int unsigned base;
    int unsigned hot;
    int          w_cur;
    logic        mark;
    sent = 0;
    mark = 1'($urandom_range(0, 1));   // first graph may keep the forest from before
    while (sent < budget) begin
      w_cur = int'($urandom_range(0, 65535)) - 32768;
      if (lim >= 16 && $urandom_range(0, 3) == 0) begin
        span = 1 << $urandom_range(3, (lim >= 64) ? 6 : 4);
        base = $urandom_range(0, lim - span);
        for (int s = 1; s < span; s = s * 2) begin
          for (int i = 0; i < span; i = i + 2 * s) begin
            send_graph_edge(mark, ufcef_pkg::VIDX_W'(base + i),
                            ufcef_pkg::VIDX_W'(base + i + s), w_cur);
            mark = 1'b0;
            sent++;
          end
        end
      end
      hot = (lim > 8) ? $urandom_range(0, lim - 8) : 0;
      repeat ($urandom_range(6, 30)) begin
        send_graph_edge(mark, pick_end(lim, hot), pick_end(lim, hot), w_cur);
        mark = 1'b0;
        sent++;
      end
      mark = 1'b1;
    end
  endtask

  initial begin : stimulus
    int unsigned vc;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    new_graph_i   = 1'b0;
    end_a_i       = '0;
    end_b_i       = '0;
    edge_weight_i = '0;
    fast_mode     = 1'b0;
    hold_req      = 1'b0;
    offering      = 1'b0;
    burst_left    = 1;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // Reset count of 1024: top index, a cycle back, a self loop at the extremes.
    send_edge(1'b1, 10'd0, 10'd1023, 16'sd32767);
    send_edge(1'b0, 10'd1023, 10'd0, 16'sd32767);
    send_edge(1'b0, 10'd1023, 10'd1023, -16'sd32768);
    settle();

    // Eight vertices: range errors, a new-graph mark on a bad edge, every
    // merge case and cycles closed through merged trees.
    write_vertex_count(11'd8);
    send_edge(1'b0, 10'd8, 10'd0, 16'sd30000);
    send_edge(1'b0, 10'd0, 10'd1023, 16'sd29000);
    send_edge(1'b1, 10'd1023, 10'd1, 16'sd28000);
    send_edge(1'b0, 10'd0, 10'd1, 16'sd20000);
    send_edge(1'b0, 10'd2, 10'd3, 16'sd19000);
    send_edge(1'b0, 10'd4, 10'd0, 16'sd18000);
    send_edge(1'b0, 10'd0, 10'd5, 16'sd17000);
    send_edge(1'b0, 10'd1, 10'd2, 16'sd16000);
    send_edge(1'b0, 10'd3, 10'd5, 16'sd15000);
    send_edge(1'b0, 10'd6, 10'd7, 16'sd14000);
    send_edge(1'b0, 10'd7, 10'd6, 16'sd13000);
    send_edge(1'b0, 10'd7, 10'd3, 16'sd12000);
    send_edge(1'b0, 10'd4, 10'd4, -16'sd32768);
    settle();

    // Count above the table size acts as the table size; old links survive.
    write_vertex_count(11'd2047);
    send_edge(1'b0, 10'd1023, 10'd1000, -16'sd32768);
    send_edge(1'b0, 10'd7, 10'd1, -16'sd32768);
    send_edge(1'b1, 10'd5, 10'd5, -16'sd32768);
    settle();

    write_vertex_count(11'd0);
    send_edge(1'b0, 10'd0, 10'd0, 16'sd0);
    settle();

    // Back-to-back self loops at both extreme weights.
    write_vertex_count(11'd1);
    fast_mode = 1'b1;
    send_edge(1'b1, 10'd0, 10'd0, 16'sd32767);
    repeat (POS_RUN) send_edge(1'b0, 10'd0, 10'd0, 16'sd32767);
    send_edge(1'b0, 10'd0, 10'd0, -16'sd1);
    send_edge(1'b1, 10'd0, 10'd0, -16'sd32768);
    repeat (NEG_RUN) send_edge(1'b0, 10'd0, 10'd0, -16'sd32768);
    fast_mode = 1'b0;
    settle();

    // Random phases; the first opens under a long receiver hold-off so the
    // block backs up onto its input.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: vc = 16;
        1: vc = 1024;
        2: vc = 0;
        3: vc = 2047;
        4: vc = 1;
        5: vc = 2;
        6: vc = 512;
        7: vc = 100;
        8: vc = $urandom_range(3, 2047);
        default: vc = 1024;
      endcase
      write_vertex_count(ufcef_pkg::VCNT_W'(vc));
      if (p == 0) hold_req = 1'b1;
      run_phase((vc > FOREST_SIZE) ? FOREST_SIZE : vc, PHASE_WORDS);
      settle();
    end

    tracker.report_leftovers();
    if (tracker.mismatches == 0) begin
      $display("union_find_cycle_edge_filter: match");
    end else begin
      $display("union_find_cycle_edge_filter: mismatch");
    end
    $finish;
  end

endmodule
